/* rtl/mme_pkg.sv */
`timescale 1ns / 1ps

package mme_pkg;

	localparam int WORD_W = 32;
	localparam int PROD_W = 64;
	localparam int REG_W  = 4;
	localparam int FRAC_W = 16;

	localparam logic [REG_W-1:0] REG_RESET = 4'd8;

	// Command codes.
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_MUL    = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_A_ROWS = 2'd0;
	localparam logic [1:0] CFG_A_COLS = 2'd1;
	localparam logic [1:0] CFG_B_ROWS = 2'd2;
	localparam logic [1:0] CFG_B_COLS = 2'd3;

	localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

	// Tag that travels down the multiply-accumulate pipeline with each term.
	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       zero;
		logic       final_elem;
		logic [2:0] row;
		logic [2:0] col;
	} mac_tag_t;

	// One finished product element.
	typedef struct packed {
		logic              valid;
		logic              final_elem;
		logic [2:0]        row;
		logic [2:0]        col;
		logic [WORD_W-1:0] product;
	} mac_res_t;

endpackage

/* rtl/mme_ram.sv */
`timescale 1ns / 1ps

module mme_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [mme_pkg::WORD_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [mme_pkg::WORD_W-1:0] rdata
);

	logic [mme_pkg::WORD_W-1:0] mem [DEPTH];
	logic [mme_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mme_mac.sv */
`timescale 1ns / 1ps

module mme_mac #(
	parameter int MAX_DIM = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  mme_pkg::mac_tag_t          tag_s1,
	input  logic [mme_pkg::WORD_W-1:0] a_data,
	input  logic [mme_pkg::WORD_W-1:0] b_data,
	output mme_pkg::mac_res_t          res
);

	localparam int ACC_W = mme_pkg::PROD_W + 1 + $clog2(MAX_DIM);
	localparam int HI_LSB = mme_pkg::FRAC_W + mme_pkg::WORD_W - 1;

	logic signed [mme_pkg::PROD_W-1:0] mult;
	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	mme_pkg::mac_tag_t                 tag_s2;
	logic [ACC_W-1:0]                  acc_q;
	logic [ACC_W-1:0]                  sum;
	logic [ACC_W-1:0]                  base;
	logic [ACC_W-1-HI_LSB:0]           hi;
	logic [mme_pkg::WORD_W-1:0]        sat;

	assign mult = $signed(a_data) * $signed(b_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= tag_s1.zero ? '0 : mult;
		end
	end

	assign base = tag_s2.first ? '0 : acc_q;
	assign sum  = base + {{(ACC_W - mme_pkg::PROD_W){prod_s2[mme_pkg::PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (en && tag_s2.valid) begin
			acc_q <= sum;
		end
	end

	// The sum fits Q16.16 only when every bit from bit 47 up equals the sign.
	assign hi = sum[ACC_W-1:HI_LSB];
	always_comb begin
		if (!sum[ACC_W-1] && (hi != '0)) begin
			sat = mme_pkg::Q_MAX;
		end else if (sum[ACC_W-1] && !(&hi)) begin
			sat = mme_pkg::Q_MIN;
		end else begin
			sat = sum[mme_pkg::FRAC_W +: mme_pkg::WORD_W];
		end
	end

	assign res.valid      = en && tag_s2.valid && tag_s2.last;
	assign res.final_elem = tag_s2.final_elem;
	assign res.row        = tag_s2.row;
	assign res.col        = tag_s2.col;
	assign res.product    = sat;

endmodule

/* rtl/matrix_multiply_engine.sv */
`timescale 1ns / 1ps

// Dense matrix multiply over signed Q16.16 elements.
// Command channel (cmd_valid / cmd_stall): operation 0 or 1 writes value into A or B at
// row, col; operation 2 multiplies A by B. Each load gives one result beat (status ok or
// index out of range) in the output register in the cycle after acceptance.
// A multiply streams the product row-major on the result channel (res_valid / res_stall),
// with last on the final element; a mismatch of A's columns and B's rows gives a single
// order-error beat instead. Terms enter the shared multiply-accumulate pipeline back to
// back, rows * inner * cols of them (rows * cols when the inner size is zero); 512 at the
// default size. One command is in flight at a time; cmd_stall is high while a multiply
// runs and while a finished beat waits in the output register under res_stall. A stall
// on the result side freezes the whole pipeline, memory reads included, so nothing is lost.
// Configuration (cfg_valid / cfg_ready, always ready) sets the four dimension registers;
// the user must see that it is written only while idle; the block does not enforce this.
// Reset returns every dimension to 8 and empties the pipeline; the element memories are
// not cleared and hold no meaning until loaded.
module matrix_multiply_engine #(
	parameter int MAX_DIM = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [1:0]                 operation,
	input  logic [2:0]                 row,
	input  logic [2:0]                 col,
	input  logic signed [31:0]         value,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [1:0]                 status,
	output logic [2:0]                 out_row,
	output logic [2:0]                 out_col,
	output logic signed [31:0]         product,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [mme_pkg::REG_W-1:0]  cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int EW    = mme_pkg::REG_W + 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]                 state_q;
	logic [mme_pkg::REG_W-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DW-1:0]              m_q, n_q, p_q;
	logic [IW-1:0]              i_q, j_q, k_q;
	mme_pkg::mac_tag_t          tag_s1;
	mme_pkg::mac_tag_t          issue_tag;
	mme_pkg::mac_res_t          mac_res;
	logic [mme_pkg::WORD_W-1:0] a_rdata, b_rdata;

	logic                       res_valid_q;
	logic [1:0]                 status_q;
	logic [2:0]                 out_row_q, out_col_q;
	logic [mme_pkg::WORD_W-1:0] product_q;
	logic                       last_q;

	logic          adv;
	logic          cmd_acc;
	logic [EW-1:0] eff_a_rows, eff_a_cols, eff_b_rows, eff_b_cols;
	logic [EW-1:0] lim_r, lim_c;
	logic          in_range;
	logic          order_bad;
	logic          mul_go;
	logic          cmd_push;
	logic [1:0]    cmd_status;
	logic [AW-1:0] load_addr, a_raddr, b_raddr;
	logic          k_end, j_end, i_end;
	logic          a_we, b_we;

	function automatic logic [EW-1:0] eff_dim(input logic [mme_pkg::REG_W-1:0] v);
		logic [EW-1:0] x;
		x = {1'b0, v};
		return (x > EW'(MAX_DIM)) ? EW'(MAX_DIM) : x;
	endfunction

	assign eff_a_rows = eff_dim(a_rows_q);
	assign eff_a_cols = eff_dim(a_cols_q);
	assign eff_b_rows = eff_dim(b_rows_q);
	assign eff_b_cols = eff_dim(b_cols_q);

	// The pipeline moves only when the output register can take a beat.
	assign adv       = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE) || !adv;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	assign lim_r    = (operation == mme_pkg::OP_LOAD_A) ? eff_a_rows : eff_b_rows;
	assign lim_c    = (operation == mme_pkg::OP_LOAD_A) ? eff_a_cols : eff_b_cols;
	assign in_range = (EW'(row) < lim_r) && (EW'(col) < lim_c);
	assign order_bad = (a_cols_q != b_rows_q);
	assign load_addr = AW'(int'(row) * MAX_DIM + int'(col));

	assign a_we = cmd_acc && (operation == mme_pkg::OP_LOAD_A) && in_range;
	assign b_we = cmd_acc && (operation == mme_pkg::OP_LOAD_B) && in_range;

	assign mul_go = cmd_acc && (operation == mme_pkg::OP_MUL) && !order_bad
		&& (eff_a_rows != '0) && (eff_b_cols != '0);

	always_comb begin
		cmd_push   = 1'b0;
		cmd_status = mme_pkg::ST_OK;
		case (operation)
			mme_pkg::OP_LOAD_A, mme_pkg::OP_LOAD_B: begin
				cmd_push   = cmd_acc;
				cmd_status = in_range ? mme_pkg::ST_OK : mme_pkg::ST_RANGE;
			end
			mme_pkg::OP_MUL: begin
				cmd_push   = cmd_acc && order_bad;
				cmd_status = mme_pkg::ST_ORDER;
			end
			default: begin
				cmd_push   = 1'b0;
				cmd_status = mme_pkg::ST_OK;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::REG_RESET;
			a_cols_q <= mme_pkg::REG_RESET;
			b_rows_q <= mme_pkg::REG_RESET;
			b_cols_q <= mme_pkg::REG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mme_pkg::CFG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::CFG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::CFG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::CFG_B_COLS: b_cols_q <= cfg_data;
				default: a_rows_q <= a_rows_q;
			endcase
		end
	end

	// Term sequencer: k runs fastest, then the column j, then the row i.
	assign k_end = (n_q == '0) || ((DW'(k_q) + DW'(1)) == n_q);
	assign j_end = (DW'(j_q) + DW'(1)) == p_q;
	assign i_end = (DW'(i_q) + DW'(1)) == m_q;

	assign a_raddr = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign b_raddr = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	always_comb begin
		issue_tag            = '0;
		issue_tag.valid      = (state_q == S_RUN);
		issue_tag.first      = (k_q == '0);
		issue_tag.last       = k_end;
		issue_tag.zero       = (n_q == '0);
		issue_tag.final_elem = k_end && j_end && i_end;
		issue_tag.row        = 3'(i_q);
		issue_tag.col        = 3'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tag_s1  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			m_q     <= '0;
			n_q     <= '0;
			p_q     <= '0;
		end else begin
			if (adv) begin
				tag_s1 <= issue_tag;
			end
			case (state_q)
				S_IDLE: begin
					if (mul_go) begin
						state_q <= S_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						m_q     <= DW'(eff_a_rows);
						n_q     <= DW'(eff_a_cols);
						p_q     <= DW'(eff_b_cols);
					end
				end
				S_RUN: begin
					if (adv) begin
						if (!k_end) begin
							k_q <= k_q + IW'(1);
						end else begin
							k_q <= '0;
							if (!j_end) begin
								j_q <= j_q + IW'(1);
							end else begin
								j_q <= '0;
								i_q <= i_q + IW'(1);
								if (i_end) begin
									state_q <= S_DRAIN;
								end
							end
						end
					end
				end
				S_DRAIN: begin
					if (mac_res.valid && mac_res.final_elem) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mme_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (load_addr),
		.wdata (value),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mme_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (load_addr),
		.wdata (value),
		.re    (adv),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mme_mac #(
		.MAX_DIM (MAX_DIM)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.tag_s1 (tag_s1),
		.a_data (a_rdata),
		.b_data (b_rdata),
		.res    (mac_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_push || mac_res.valid) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push) begin
			status_q  <= cmd_status;
			out_row_q <= (operation == mme_pkg::OP_MUL) ? 3'd0 : row;
			out_col_q <= (operation == mme_pkg::OP_MUL) ? 3'd0 : col;
			product_q <= '0;
			last_q    <= 1'b1;
		end else if (mac_res.valid) begin
			status_q  <= mme_pkg::ST_OK;
			out_row_q <= mac_res.row;
			out_col_q <= mac_res.col;
			product_q <= mac_res.product;
			last_q    <= mac_res.final_elem;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign product   = product_q;
	assign last      = last_q;

	a_mac_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.valid |-> (state_q != S_IDLE))
		else $error("product element produced while idle");

	a_mac_room: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.valid |-> !(res_valid_q && res_stall))
		else $error("product element overwrote a held result beat");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_res.valid && mac_res.final_elem) |=> (res_valid && last))
		else $error("final product element not marked last");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> ((DW'(i_q) < m_q) && (DW'(j_q) < p_q)))
		else $error("sequencer index beyond matrix size");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> ((state_q == S_IDLE) && !tag_s1.valid))
		else $error("element write while a multiply is in flight");

endmodule
